// File: src/hdm_pkg.sv
// Shared types, codes and constants of the Hamming distance matrix unit.
package hdm_pkg;

  // Fixed field widths of the item and result words.
  localparam int unsigned FcW   = 6;
  localparam int unsigned RowW  = 32;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned OutW  = 16;
  // Width of the effective feature count, which can reach 63.
  localparam int unsigned FeatNW = 7;

  // Defaults of the top level parameters.
  localparam int unsigned MaxFeaturesDef = 32;
  localparam int unsigned CountWidthDef  = 16;

  // Reset value of the feature count register.
  localparam logic [FcW-1:0] FcReset = 6'd32;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  // Command broadcast from the decoder to every lane.
  typedef struct packed {
    logic              add;
    logic              clr;
    logic              rd_load;
    logic [FeatNW-1:0] feat_n;
    logic [IdxW-1:0]   rd_hi;
  } lane_cmd_t;

  // Side information of a read that travels with it to the merge stage.
  typedef struct packed {
    logic [IdxW-1:0] lo;
    logic            bad;
    logic [OutW-1:0] rows;
  } rd_ctrl_t;

endpackage

// File: src/hdm_if.sv
// Valid/ready channel interfaces for input words and result words.
interface hdm_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [hdm_pkg::RowW-1:0]    row_bits;
  logic [hdm_pkg::IdxW-1:0]    index_a;
  logic [hdm_pkg::IdxW-1:0]    index_b;

  modport source (output valid, func, row_bits, index_a, index_b, input ready);
  modport sink   (input valid, func, row_bits, index_a, index_b, output ready);
endinterface

interface hdm_out_if;
  logic                        valid;
  logic                        ready;
  logic [hdm_pkg::OutW-1:0]    distance;
  logic [hdm_pkg::OutW-1:0]    rows_seen;
  logic                        bad_index;

  modport source (output valid, distance, rows_seen, bad_index, input ready);
  modport sink   (input valid, distance, rows_seen, bad_index, output ready);
endinterface

// File: src/hamming_distance_matrix_unit.sv
// Pairwise Hamming distance matrix unit. The unit takes one word per clock cycle
// whenever the result side is not stalled: a data row updates all pair counters of the
// upper triangle at once (one lane of counters per feature with a higher partner, all held
// in flip-flops), a clear zeroes them, and a read word yields its result word through
// the lane read register and then the merge result register.
// Adds and clears produce no result word. Input readiness drops only while a finished
// result waits at the output and another read is already held in the lane stage.
// The user must write the feature count register through cfg_we_i only while the unit
// is idle; the block does not enforce this. Values above MAX_FEATURES act as MAX_FEATURES.
module hamming_distance_matrix_unit #(
  parameter int unsigned MAX_FEATURES = hdm_pkg::MaxFeaturesDef,
  parameter int unsigned COUNT_WIDTH  = hdm_pkg::CountWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [hdm_pkg::FcW-1:0]  cfg_wdata_i,
  hdm_in_if.sink                   in_i,
  hdm_out_if.source                out_o
);

  logic [hdm_pkg::FcW-1:0]                  fc_q;
  logic [hdm_pkg::FeatNW-1:0]               feat_n;
  logic [COUNT_WIDTH-1:0]                   rows_q, rows_d;
  logic [COUNT_WIDTH+15:0]                  rows_ext;
  logic                                     s1_free;
  logic                                     accept;
  logic                                     is_add, is_read, is_clear;
  logic [MAX_FEATURES+31:0]                 bits_ext;
  logic [MAX_FEATURES-1:0]                  bits;
  logic [hdm_pkg::IdxW-1:0]                 lo, hi;
  hdm_pkg::lane_cmd_t                       cmd;
  hdm_pkg::rd_ctrl_t                        ctrl;
  logic [MAX_FEATURES-2:0][COUNT_WIDTH-1:0] lane_data;

  // Feature count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= hdm_pkg::FcReset;
    end else if (cfg_we_i) begin
      fc_q <= cfg_wdata_i;
    end
  end

  // Effective feature count, capped at MAX_FEATURES.
  assign feat_n = ({1'b0, fc_q} > hdm_pkg::FeatNW'(MAX_FEATURES)) ?
                  hdm_pkg::FeatNW'(MAX_FEATURES) : {1'b0, fc_q};

  // Word decode.
  assign in_i.ready = s1_free;
  assign accept     = in_i.valid && s1_free;

  always_comb begin
    is_add   = 1'b0;
    is_read  = 1'b0;
    is_clear = 1'b0;
    unique case (in_i.func)
      hdm_pkg::FUNC_ADD:   is_add   = accept;
      hdm_pkg::FUNC_READ:  is_read  = accept;
      hdm_pkg::FUNC_CLEAR: is_clear = accept;
      default: ;
    endcase
  end

  // Features beyond the row word read as zero.
  assign bits_ext = {{MAX_FEATURES{1'b0}}, in_i.row_bits};
  assign bits     = bits_ext[MAX_FEATURES-1:0];

  // Order the pair so that the lower index picks the lane.
  assign lo = (in_i.index_a < in_i.index_b) ? in_i.index_a : in_i.index_b;
  assign hi = (in_i.index_a < in_i.index_b) ? in_i.index_b : in_i.index_a;

  // Saturating row counter.
  always_comb begin
    rows_d = rows_q;
    if (is_clear) begin
      rows_d = '0;
    end else if (is_add && !(&rows_q)) begin
      rows_d = rows_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else begin
      rows_q <= rows_d;
    end
  end

  assign rows_ext = {16'b0, rows_q};

  assign cmd.add     = is_add;
  assign cmd.clr     = is_clear;
  assign cmd.rd_load = is_read;
  assign cmd.feat_n  = feat_n;
  assign cmd.rd_hi   = hi;

  assign ctrl.lo   = lo;
  assign ctrl.bad  = ({2'b00, in_i.index_a} >= feat_n) || ({2'b00, in_i.index_b} >= feat_n);
  assign ctrl.rows = rows_ext[hdm_pkg::OutW-1:0];

  // One lane of counters per feature that has a higher partner.
  for (genvar l = 0; l < MAX_FEATURES - 1; l++) begin : g_lane
    hdm_lane #(
      .MAX_FEATURES (MAX_FEATURES),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .LANE         (l)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .bits_i    (bits),
      .rd_data_o (lane_data[l])
    );
  end

  hdm_merge #(
    .MAX_FEATURES (MAX_FEATURES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lane_data_i (lane_data),
    .rd_accept_i (is_read),
    .ctrl_i      (ctrl),
    .s1_free_o   (s1_free),
    .out_o       (out_o)
  );

endmodule

// File: src/hdm_lane.sv
// One lane: the saturating pair counters of one feature against all higher features.
module hdm_lane #(
  parameter int unsigned MAX_FEATURES = hdm_pkg::MaxFeaturesDef,
  parameter int unsigned COUNT_WIDTH  = hdm_pkg::CountWidthDef,
  parameter int unsigned LANE         = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hdm_pkg::lane_cmd_t        cmd_i,
  input  logic [MAX_FEATURES-1:0]   bits_i,
  output logic [COUNT_WIDTH-1:0]    rd_data_o
);

  localparam int unsigned Depth = MAX_FEATURES - 1 - LANE;

  logic [COUNT_WIDTH-1:0] cnt_q [Depth];
  logic [COUNT_WIDTH-1:0] cnt_d [Depth];
  logic [COUNT_WIDTH-1:0] rd_sel;
  logic [COUNT_WIDTH-1:0] rd_q;

  // Each counter steps when its two feature bits differ and both features are in use.
  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      cnt_d[j] = cnt_q[j];
      if (cmd_i.clr) begin
        cnt_d[j] = '0;
      end else if (cmd_i.add && (hdm_pkg::FeatNW'(LANE + 1 + j) < cmd_i.feat_n) &&
                   (bits_i[LANE+1+j] ^ bits_i[LANE]) && !(&cnt_q[j])) begin
        cnt_d[j] = cnt_q[j] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < Depth; j++) begin
        cnt_q[j] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Pick the counter of the higher feature; no match reads as zero.
  always_comb begin
    rd_sel = '0;
    for (int j = 0; j < Depth; j++) begin
      if ({2'b00, cmd_i.rd_hi} == hdm_pkg::FeatNW'(LANE + 1 + j)) begin
        rd_sel = cnt_q[j];
      end
    end
  end

  // The read value is captured when the read word is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_load) begin
      rd_q <= rd_sel;
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: src/hdm_merge.sv
// Merge stage: picks the lane of the lower feature and drives the result register.
module hdm_merge #(
  parameter int unsigned MAX_FEATURES = hdm_pkg::MaxFeaturesDef,
  parameter int unsigned COUNT_WIDTH  = hdm_pkg::CountWidthDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [MAX_FEATURES-2:0][COUNT_WIDTH-1:0]  lane_data_i,
  input  logic                                      rd_accept_i,
  input  hdm_pkg::rd_ctrl_t                         ctrl_i,
  output logic                                      s1_free_o,
  hdm_out_if.source                                 out_o
);

  logic                      s1_valid_q, s1_valid_d;
  hdm_pkg::rd_ctrl_t         ctrl_q;
  logic                      out_valid_q, out_valid_d;
  logic                      out_adv;
  logic [COUNT_WIDTH-1:0]    sel;
  logic [COUNT_WIDTH+15:0]   sel_ext;
  logic [hdm_pkg::OutW-1:0]  dist_q, rows_q;
  logic                      bad_q;

  // The result register frees when empty or taken; the lane stage drains into it.
  assign out_adv    = !out_valid_q || out_o.ready;
  assign s1_free_o  = !s1_valid_q || out_adv;
  assign s1_valid_d = s1_free_o ? rd_accept_i : s1_valid_q;
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_accept_i && s1_free_o) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Select the lane of the lower index; a repeated index matches no counter.
  always_comb begin
    sel = '0;
    for (int l = 0; l < MAX_FEATURES - 1; l++) begin
      if ({2'b00, ctrl_q.lo} == hdm_pkg::FeatNW'(l)) begin
        sel = lane_data_i[l];
      end
    end
  end

  assign sel_ext = {16'b0, sel};

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      dist_q <= ctrl_q.bad ? '0 : sel_ext[hdm_pkg::OutW-1:0];
      rows_q <= ctrl_q.rows;
      bad_q  <= ctrl_q.bad;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.distance  = dist_q;
  assign out_o.rows_seen = rows_q;
  assign out_o.bad_index = bad_q;

endmodule

// File: src/hdm_checker.sv
// Port-level checks of the Hamming distance matrix unit, bound to the top level.
module hdm_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [hdm_pkg::OutW-1:0] distance_i,
  input logic [hdm_pkg::OutW-1:0] rows_seen_i,
  input logic                     bad_index_i
);

  // A stalled result word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(distance_i) && $stable(rows_seen_i) && $stable(bad_index_i))
    else $error("stalled result word changed");

  // A bad index always reports a zero distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_index_i |-> distance_i == '0)
    else $error("bad index with nonzero distance");

  // The input side is held off only by a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // A result word cannot appear in the cycle right after reset release.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result word right after reset");

  // An offered word is always taken while the result register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !out_valid_i |-> in_ready_i)
    else $error("offered word refused while the result register is empty");

endmodule

bind hamming_distance_matrix_unit hdm_checker u_hdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .distance_i  (out_o.distance),
  .rows_seen_i (out_o.rows_seen),
  .bad_index_i (out_o.bad_index)
);
